// File: hdl/ftpq_pkg.sv
// Shared types, codes and defaults for the priority ready queue.
package ftpq_pkg;

    localparam int NUM_SLOTS_DEF = 16;
    localparam int ID_BITS_DEF   = 8;
    localparam int KEY_BITS_DEF  = 8;

    localparam int ACTION_W = 2;
    localparam int FIELD_W  = 8;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD    = 2'd0,
        ACT_PEEK   = 2'd1,
        ACT_POP    = 2'd2,
        ACT_REMOVE = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_FULL      = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // controller -> datapath
    typedef struct packed {
        logic load;     // latch request fields, clear search result
        logic idx_clr;  // restart slot counter
        logic rd;       // read slot at counter, advance counter
        logic sweep;    // read belongs to rank fix-up pass
        logic commit;   // apply search result to state
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic idx_last;
        logic need_sweep;
    } t_sts;

endpackage

// File: hdl/ftpq_ctrl.sv
// Sequencer for the queue: search pass, commit, rank fix-up pass, response.
module ftpq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  ftpq_pkg::t_sts  i_sts,
    output ftpq_pkg::t_cmd  o_cmd,
    output logic            o_busy,
    output logic            o_done
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_SCAN   = 7'b0000010,
        S_DRAIN  = 7'b0000100,
        S_COMMIT = 7'b0001000,
        S_SWEEP  = 7'b0010000,
        S_FLUSH  = 7'b0100000,
        S_RESP   = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state       = r_state;
        o_cmd         = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.idx_clr = 1'b1;
                    n_state       = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.rd = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                o_cmd.commit  = 1'b1;
                o_cmd.idx_clr = 1'b1;
                n_state       = i_sts.need_sweep ? S_SWEEP : S_RESP;
            end
            S_SWEEP: begin
                o_cmd.rd    = 1'b1;
                o_cmd.sweep = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_RESP);

    a_resp_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RESP) |=> (r_state == S_IDLE))
        else $error("response not followed by idle");

    a_accept_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (r_state == S_SCAN))
        else $error("accepted request did not start search");

    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

endmodule

// File: hdl/ftpq_dp.sv
// Slot store, search compare, rank fix-up and result registers of the queue.
module ftpq_dp #(
    parameter int NUM_SLOTS = ftpq_pkg::NUM_SLOTS_DEF,
    parameter int ID_BITS   = ftpq_pkg::ID_BITS_DEF,
    parameter int KEY_BITS  = ftpq_pkg::KEY_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  ftpq_pkg::t_cmd                  i_cmd,
    output ftpq_pkg::t_sts                  o_sts,
    input  logic [ftpq_pkg::ACTION_W-1:0]   i_action,
    input  logic [ftpq_pkg::FIELD_W-1:0]    i_entry_id,
    input  logic [ftpq_pkg::FIELD_W-1:0]    i_priority_req,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_data,
    output logic [ftpq_pkg::STATUS_W-1:0]   o_status,
    output logic [ftpq_pkg::FIELD_W-1:0]    o_out_id,
    output logic [ftpq_pkg::FIELD_W-1:0]    o_out_priority,
    output logic                            o_now_empty,
    output logic [ftpq_pkg::OCC_W-1:0]      o_occupancy
);

    localparam int RB     = $clog2(NUM_SLOTS);
    localparam int CB     = $clog2(NUM_SLOTS + 1);
    localparam int WORD_W = ID_BITS + KEY_BITS + RB;

    // word layout: {id, key, arrival rank}
    logic [WORD_W-1:0] mem [NUM_SLOTS];

    ftpq_pkg::t_action r_act;
    ftpq_pkg::t_status r_status;
    logic [ID_BITS-1:0]  r_req_id;
    logic [KEY_BITS-1:0] r_req_key;
    logic                r_lvf;
    logic [CB-1:0]       r_count;
    logic [NUM_SLOTS-1:0] r_used;
    logic [RB-1:0]       r_idx;

    logic                r_rd_vld;
    logic                r_rd_sweep;
    logic [RB-1:0]       r_rd_idx;
    logic                r_rd_used;
    logic [WORD_W-1:0]   r_rd_word;

    logic                r_found;
    logic [RB-1:0]       r_sel_idx;
    logic [ID_BITS-1:0]  r_sel_id;
    logic [KEY_BITS-1:0] r_sel_key;
    logic [RB-1:0]       r_sel_rank;

    logic [ID_BITS-1:0]  r_out_id;
    logic [KEY_BITS-1:0] r_out_key;

    logic [ID_BITS-1:0]  rd_id;
    logic [KEY_BITS-1:0] rd_key;
    logic [RB-1:0]       rd_rank;
    logic                key_better;
    logic                better;
    logic                take;
    logic                sweep_we;
    logic                commit_we;
    logic                mem_we;
    logic [RB-1:0]       mem_wa;
    logic [WORD_W-1:0]   mem_wd;

    assign rd_id   = r_rd_word[WORD_W-1 -: ID_BITS];
    assign rd_key  = r_rd_word[RB+KEY_BITS-1 -: KEY_BITS];
    assign rd_rank = r_rd_word[RB-1:0];

    assign key_better = r_lvf ? (rd_key < r_sel_key) : (rd_key > r_sel_key);
    assign better     = (rd_key != r_sel_key) ? key_better : (rd_rank < r_sel_rank);

    always_comb begin
        take = 1'b0;
        case (r_act)
            ftpq_pkg::ACT_ADD:    take = !r_rd_used && !r_found;
            ftpq_pkg::ACT_PEEK,
            ftpq_pkg::ACT_POP:    take = r_rd_used && (!r_found || better);
            ftpq_pkg::ACT_REMOVE: take = r_rd_used && (rd_id == r_req_id)
                                         && (rd_key == r_req_key)
                                         && (!r_found || (rd_rank < r_sel_rank));
            default:              take = 1'b0;
        endcase
        take = take && r_rd_vld && !r_rd_sweep;
    end

    // entries younger than the freed one move up one place
    assign sweep_we  = r_rd_vld && r_rd_sweep && r_rd_used && (rd_rank > r_sel_rank);
    assign commit_we = i_cmd.commit && (r_act == ftpq_pkg::ACT_ADD) && r_found;
    assign mem_we    = commit_we || sweep_we;
    assign mem_wa    = commit_we ? r_sel_idx : r_rd_idx;
    assign mem_wd    = commit_we ? {r_req_id, r_req_key, RB'(r_count)}
                                 : {rd_id, rd_key, rd_rank - 1'b1};

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        if (i_cmd.rd) begin
            r_rd_word <= mem[r_idx];
        end
    end

    // request latch, read pipeline and search result
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_act     <= ftpq_pkg::t_action'(i_action);
            r_req_id  <= ID_BITS'(i_entry_id);
            r_req_key <= KEY_BITS'(i_priority_req);
        end
        r_rd_idx  <= r_idx;
        r_rd_used <= r_used[r_idx];
        if (take) begin
            r_sel_idx  <= r_rd_idx;
            r_sel_id   <= rd_id;
            r_sel_key  <= rd_key;
            r_sel_rank <= rd_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvf      <= 1'b1;
            r_count    <= '0;
            r_used     <= '0;
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_rd_sweep <= 1'b0;
            r_found    <= 1'b0;
            r_status   <= ftpq_pkg::ST_OK;
            r_out_id   <= '0;
            r_out_key  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_lvf <= i_cfg_data;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.rd) begin
                r_idx <= r_idx + 1'b1;
            end
            r_rd_vld   <= i_cmd.rd;
            r_rd_sweep <= i_cmd.sweep;
            if (i_cmd.load) begin
                r_found <= 1'b0;
            end else if (take) begin
                r_found <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_out_id  <= '0;
                r_out_key <= '0;
                case (r_act)
                    ftpq_pkg::ACT_ADD: begin
                        if (r_found) begin
                            r_used[r_sel_idx] <= 1'b1;
                            r_count           <= r_count + 1'b1;
                            r_status          <= ftpq_pkg::ST_OK;
                        end else begin
                            r_status <= ftpq_pkg::ST_FULL;
                        end
                    end
                    ftpq_pkg::ACT_PEEK,
                    ftpq_pkg::ACT_POP: begin
                        if (r_found) begin
                            r_out_id  <= r_sel_id;
                            r_out_key <= r_sel_key;
                            r_status  <= ftpq_pkg::ST_OK;
                            if (r_act == ftpq_pkg::ACT_POP) begin
                                r_used[r_sel_idx] <= 1'b0;
                                r_count           <= r_count - 1'b1;
                            end
                        end else begin
                            r_status <= ftpq_pkg::ST_EMPTY;
                        end
                    end
                    ftpq_pkg::ACT_REMOVE: begin
                        if (r_found) begin
                            r_used[r_sel_idx] <= 1'b0;
                            r_count           <= r_count - 1'b1;
                            r_status          <= ftpq_pkg::ST_OK;
                        end else begin
                            r_status <= ftpq_pkg::ST_NOT_FOUND;
                        end
                    end
                    default: begin
                        r_status <= ftpq_pkg::ST_OK;
                    end
                endcase
            end
        end
    end

    assign o_sts.idx_last   = (r_idx == RB'(NUM_SLOTS - 1));
    assign o_sts.need_sweep = r_found && ((r_act == ftpq_pkg::ACT_POP)
                                          || (r_act == ftpq_pkg::ACT_REMOVE));

    assign o_status       = r_status;
    assign o_out_id       = ftpq_pkg::FIELD_W'(r_out_id);
    assign o_out_priority = ftpq_pkg::FIELD_W'(r_out_key);
    assign o_now_empty    = (r_count == '0);
    assign o_occupancy    = ftpq_pkg::OCC_W'(r_count);

    a_count_matches_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used) == int'(r_count))
        else $error("entry count differs from used slots");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_count) <= NUM_SLOTS)
        else $error("entry count above capacity");

    a_sweep_skips_freed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sweep_we |-> (r_rd_idx != r_sel_idx))
        else $error("rank fix-up wrote the freed slot");

endmodule

// File: hdl/fifo_tie_priority_queue.sv
// Top level of the priority ready queue with first-in, first-out order on ties.
//
//   channel   direction  handshake                    fields
//   request   in         start & !busy                i_action, i_entry_id, i_priority_req
//   result    out        o_done (one cycle)           o_status, o_out_id, o_out_priority,
//                                                     o_now_empty, o_occupancy
//   config    in         i_cfg_we                     i_cfg_data (lowest_value_first)
//
// Each request reads all NUM_SLOTS slots through the one read port of the slot
// store, one a cycle. Add, peek and misses: scan, drain, commit, then result;
// busy drops in the next cycle. Pop and remove hits add a second pass over all
// slots, then a flush state, that renumbers arrival ranks. Reset (synchronous,
// low) empties the queue and selects smallest-value-first; no clearing pass is
// run. The receiver cannot stall: o_done marks each result for one cycle.
module fifo_tie_priority_queue #(
    parameter int NUM_SLOTS = ftpq_pkg::NUM_SLOTS_DEF,
    parameter int ID_BITS   = ftpq_pkg::ID_BITS_DEF,
    parameter int KEY_BITS  = ftpq_pkg::KEY_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ftpq_pkg::ACTION_W-1:0]   i_action,
    input  logic [ftpq_pkg::FIELD_W-1:0]    i_entry_id,
    input  logic [ftpq_pkg::FIELD_W-1:0]    i_priority_req,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_data,
    output logic                            o_done,
    output logic [ftpq_pkg::STATUS_W-1:0]   o_status,
    output logic [ftpq_pkg::FIELD_W-1:0]    o_out_id,
    output logic [ftpq_pkg::FIELD_W-1:0]    o_out_priority,
    output logic                            o_now_empty,
    output logic [ftpq_pkg::OCC_W-1:0]      o_occupancy
);

    ftpq_pkg::t_cmd cmd;
    ftpq_pkg::t_sts sts;

    ftpq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    ftpq_dp #(
        .NUM_SLOTS (NUM_SLOTS),
        .ID_BITS   (ID_BITS),
        .KEY_BITS  (KEY_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_action       (i_action),
        .i_entry_id     (i_entry_id),
        .i_priority_req (i_priority_req),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_status       (o_status),
        .o_out_id       (o_out_id),
        .o_out_priority (o_out_priority),
        .o_now_empty    (o_now_empty),
        .o_occupancy    (o_occupancy)
    );

endmodule

// File: test/tb_fifo_tie_priority_queue.sv
// Self-checking testbench for the priority ready queue with FIFO order on ties.
module tb_fifo_tie_priority_queue;

    localparam int SLOTS = ftpq_pkg::NUM_SLOTS_DEF;

    typedef struct packed {
        ftpq_pkg::t_status status;
        logic [7:0]        id;
        logic [7:0]        prio;
        logic              empty;
        logic [4:0]        occ;
    } t_q_result;

    // a typed answer overrides the computed one for that request
    typedef struct {
        bit        typed;
        t_q_result want;
    } t_fixed_answer;

    typedef struct {
        ftpq_pkg::t_action act;
        logic [7:0]        id;
        logic [7:0]        key;
        int                reps;
        bit                typed;
        t_q_result         want;
    } t_dir_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [ftpq_pkg::ACTION_W-1:0] i_action = '0;
    logic [ftpq_pkg::FIELD_W-1:0]  i_entry_id = '0;
    logic [ftpq_pkg::FIELD_W-1:0]  i_priority_req = '0;
    logic                          i_cfg_we = 1'b0;
    logic                          i_cfg_data = 1'b0;
    logic                          o_done;
    logic [ftpq_pkg::STATUS_W-1:0] o_status;
    logic [ftpq_pkg::FIELD_W-1:0]  o_out_id;
    logic [ftpq_pkg::FIELD_W-1:0]  o_out_priority;
    logic                          o_now_empty;
    logic [ftpq_pkg::OCC_W-1:0]    o_occupancy;

    // shadow of the queue contents
    bit         q_used [SLOTS] = '{default: 1'b0};
    logic [7:0] q_id   [SLOTS] = '{default: 8'h00};
    logic [7:0] q_key  [SLOTS] = '{default: 8'h00};
    int         q_rank [SLOTS] = '{default: 0};
    int         q_count = 0;
    bit         lowest_first = 1'b1;

    t_q_result     pending_results [$];
    t_fixed_answer fixed_answers [$];
    logic [15:0]   recent_adds [$];
    int            n_errors = 0;
    int            n_results = 0;
    int            burst_left = 0;

    t_dir_row dir_rows [17] = '{
        '{ftpq_pkg::ACT_PEEK,   8'h00, 8'h00, 1,  1'b1,
          '{ftpq_pkg::ST_EMPTY,     8'h00, 8'h00, 1'b1, 5'd0}},
        '{ftpq_pkg::ACT_POP,    8'h00, 8'h00, 1,  1'b1,
          '{ftpq_pkg::ST_EMPTY,     8'h00, 8'h00, 1'b1, 5'd0}},
        '{ftpq_pkg::ACT_REMOVE, 8'h05, 8'h05, 1,  1'b1,
          '{ftpq_pkg::ST_NOT_FOUND, 8'h00, 8'h00, 1'b1, 5'd0}},
        '{ftpq_pkg::ACT_ADD,    8'hFF, 8'h00, 1,  1'b1,
          '{ftpq_pkg::ST_OK,        8'h00, 8'h00, 1'b0, 5'd1}},
        '{ftpq_pkg::ACT_ADD,    8'h00, 8'hFF, 1,  1'b1,
          '{ftpq_pkg::ST_OK,        8'h00, 8'h00, 1'b0, 5'd2}},
        '{ftpq_pkg::ACT_ADD,    8'h11, 8'h00, 1,  1'b1,
          '{ftpq_pkg::ST_OK,        8'h00, 8'h00, 1'b0, 5'd3}},
        '{ftpq_pkg::ACT_ADD,    8'h11, 8'h00, 1,  1'b1,
          '{ftpq_pkg::ST_OK,        8'h00, 8'h00, 1'b0, 5'd4}},
        '{ftpq_pkg::ACT_PEEK,   8'h00, 8'h00, 1,  1'b1,
          '{ftpq_pkg::ST_OK,        8'hFF, 8'h00, 1'b0, 5'd4}},
        '{ftpq_pkg::ACT_REMOVE, 8'h11, 8'h00, 1,  1'b1,
          '{ftpq_pkg::ST_OK,        8'h00, 8'h00, 1'b0, 5'd3}},
        '{ftpq_pkg::ACT_REMOVE, 8'h00, 8'hFE, 1,  1'b1,
          '{ftpq_pkg::ST_NOT_FOUND, 8'h00, 8'h00, 1'b0, 5'd3}},
        '{ftpq_pkg::ACT_POP,    8'h00, 8'h00, 1,  1'b1,
          '{ftpq_pkg::ST_OK,        8'hFF, 8'h00, 1'b0, 5'd2}},
        '{ftpq_pkg::ACT_POP,    8'h00, 8'h00, 1,  1'b1,
          '{ftpq_pkg::ST_OK,        8'h11, 8'h00, 1'b0, 5'd1}},
        '{ftpq_pkg::ACT_ADD,    8'hAA, 8'h80, 15, 1'b0, '0},
        '{ftpq_pkg::ACT_ADD,    8'h55, 8'h55, 1,  1'b1,
          '{ftpq_pkg::ST_FULL,      8'h00, 8'h00, 1'b0, 5'd16}},
        '{ftpq_pkg::ACT_REMOVE, 8'hAA, 8'h80, 1,  1'b0, '0},
        '{ftpq_pkg::ACT_POP,    8'h00, 8'h00, 1,  1'b0, '0},
        '{ftpq_pkg::ACT_REMOVE, 8'h00, 8'hFF, 1,  1'b1,
          '{ftpq_pkg::ST_OK,        8'h00, 8'h00, 1'b0, 5'd13}}
    };

    fifo_tie_priority_queue i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_action       (i_action),
        .i_entry_id     (i_entry_id),
        .i_priority_req (i_priority_req),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_out_id       (o_out_id),
        .o_out_priority (o_out_priority),
        .o_now_empty    (o_now_empty),
        .o_occupancy    (o_occupancy)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    task automatic flag_error(string msg);
        $display("ERROR @%0t: %s", $time, msg);
        n_errors++;
    endtask

    function automatic void drop_slot(int s);
        q_used[s] = 1'b0;
        for (int i = 0; i < SLOTS; i++)
            if (q_used[i] && q_rank[i] > q_rank[s])
                q_rank[i]--;
        q_count--;
    endfunction

    // applies one request to the shadow queue and returns the result it gives
    function automatic t_q_result serve_request(ftpq_pkg::t_action act, logic [7:0] id,
                                                logic [7:0] key);
        t_q_result r;
        int s;
        r = '0;
        r.status = ftpq_pkg::ST_OK;
        s = SLOTS;
        case (act)
            ftpq_pkg::ACT_ADD: begin
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!q_used[i])
                        s = i;
                if (s == SLOTS) begin
                    r.status = ftpq_pkg::ST_FULL;
                end else begin
                    q_used[s] = 1'b1;
                    q_id[s]   = id;
                    q_key[s]  = key;
                    q_rank[s] = q_count;
                    q_count++;
                end
            end
            ftpq_pkg::ACT_PEEK, ftpq_pkg::ACT_POP: begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (!q_used[i])
                        continue;
                    if (s == SLOTS)
                        s = i;
                    else if (q_key[i] != q_key[s] ?
                             (lowest_first ? q_key[i] < q_key[s] : q_key[i] > q_key[s]) :
                             q_rank[i] < q_rank[s])
                        s = i;
                end
                if (s == SLOTS) begin
                    r.status = ftpq_pkg::ST_EMPTY;
                end else begin
                    r.id   = q_id[s];
                    r.prio = q_key[s];
                    if (act == ftpq_pkg::ACT_POP)
                        drop_slot(s);
                end
            end
            default: begin
                // oldest entry matching both id and key
                for (int i = 0; i < SLOTS; i++)
                    if (q_used[i] && q_id[i] == id && q_key[i] == key &&
                        (s == SLOTS || q_rank[i] < q_rank[s]))
                        s = i;
                if (s == SLOTS)
                    r.status = ftpq_pkg::ST_NOT_FOUND;
                else
                    drop_slot(s);
            end
        endcase
        r.empty = (q_count == 0);
        r.occ   = 5'(q_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_q_result     want;
        t_fixed_answer fa;
        if (i_rst_n) begin
            if (o_done === 1'b1) begin
                n_results++;
                if (pending_results.size() == 0) begin
                    flag_error($sformatf("result %0d with no request outstanding", n_results));
                end else begin
                    want = pending_results.pop_front();
                    if (o_status !== want.status)
                        flag_error($sformatf("result %0d status %0d, want %0d",
                                             n_results, o_status, want.status));
                    if (o_out_id !== want.id)
                        flag_error($sformatf("result %0d out_id %02h, want %02h",
                                             n_results, o_out_id, want.id));
                    if (o_out_priority !== want.prio)
                        flag_error($sformatf("result %0d out_priority %02h, want %02h",
                                             n_results, o_out_priority, want.prio));
                    if (o_now_empty !== want.empty)
                        flag_error($sformatf("result %0d now_empty %0d, want %0d",
                                             n_results, o_now_empty, want.empty));
                    if (o_occupancy !== want.occ)
                        flag_error($sformatf("result %0d occupancy %0d, want %0d",
                                             n_results, o_occupancy, want.occ));
                end
            end
            if (i_cfg_we)
                lowest_first = i_cfg_data;
            if (start && !busy) begin
                fa = fixed_answers.pop_front();
                want = serve_request(ftpq_pkg::t_action'(i_action), i_entry_id,
                                     i_priority_req);
                pending_results.push_back(fa.typed ? fa.want : want);
            end
        end
    end

    task automatic send_request(ftpq_pkg::t_action act, logic [7:0] id, logic [7:0] key,
                                bit typed, t_q_result want);
        fixed_answers.push_back('{typed, want});
        start          <= 1'b1;
        i_action       <= act;
        i_entry_id     <= id;
        i_priority_req <= key;
        do @(posedge i_clk); while (busy);
    endtask

    // bursts of back-to-back requests separated by random gaps
    task automatic pace();
        int gap;
        if (burst_left > 0)
            burst_left--;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 45) : $urandom_range(1, 8);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_queue_idle();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0 || busy);
    endtask

    task automatic write_order(bit lowest);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= lowest;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 3))
            0: return 8'($urandom_range(0, 3));
            1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            2: return 8'($urandom_range(8'h7E, 8'h81));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        t_dir_row          row;
        ftpq_pkg::t_action act;
        logic [7:0]        id;
        logic [7:0]        key;
        int                add_pct;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_order(1'b1);

        foreach (dir_rows[r]) begin
            row = dir_rows[r];
            repeat (row.reps) begin
                send_request(row.act, row.id, row.key, row.typed, row.want);
                pace();
            end
        end

        // alternate serving order; fill-heavy and drain-heavy phases
        for (int ph = 0; ph < 8; ph++) begin
            wait_queue_idle();
            write_order((ph % 2) != 0);
            add_pct = (ph % 4 < 2) ? $urandom_range(55, 80) : $urandom_range(25, 40);
            for (int k = 0; k < 130; k++) begin
                act = ($urandom_range(0, 99) < add_pct) ? ftpq_pkg::ACT_ADD :
                      ftpq_pkg::t_action'($urandom_range(1, 3));
                id  = pick_byte();
                key = pick_byte();
                if (act == ftpq_pkg::ACT_ADD) begin
                    recent_adds.push_back({id, key});
                    if (recent_adds.size() > 16)
                        recent_adds.delete(0);
                end else if (act == ftpq_pkg::ACT_REMOVE && recent_adds.size() != 0 &&
                             $urandom_range(0, 3) != 0) begin
                    {id, key} = recent_adds[$urandom_range(0, recent_adds.size() - 1)];
                end
                send_request(act, id, key, 1'b0, '0);
                pace();
            end
        end

        wait_queue_idle();
        repeat (40) @(posedge i_clk);
        if (pending_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_results.size()));
        if (n_errors == 0)
            $display("fifo_tie_priority_queue test passed");
        else
            $display("fifo_tie_priority_queue test failed");
        $finish;
    end

    initial begin
        #6000000;
        $display("fifo_tie_priority_queue test failed");
        $finish;
    end

endmodule
